// ===== design/ida_pkg.sv =====
// -----------------------------------------------------------------------------
// ida_pkg
// Shared constants, types and helpers for the decimal ASCII formatter.
// -----------------------------------------------------------------------------
`default_nettype none

package ida_pkg;

  // Field widths of the stream ports
  localparam int IN_W   = 64;
  localparam int CHAR_W = 8;

  // Width of the number actually converted (low bits of the value field)
  localparam int VALUE_WIDTH = 64;

  // Decimal digits needed for 2^VALUE_WIDTH - 1: floor(W * log10(2)) + 1
  localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = $clog2(VALUE_WIDTH);
  localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_SHIFT,
    CV_HOLD
  } conv_state_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SKIP,
    EM_SIGN,
    EM_DIGIT
  } emit_state_t;

  // Converter to emitter status
  typedef struct packed {
    logic valid;
    logic negative;
  } conv_res_t;

  // Shift-and-add-3 correction for one BCD digit
  function automatic logic [3:0] dabble_adj(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

  function automatic logic bcd_ok(input logic [BCD_W-1:0] b);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (b[4*i +: 4] > 4'd9) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

// ===== design/ida_conv.sv =====
// -----------------------------------------------------------------------------
// ida_conv
// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle.
// -----------------------------------------------------------------------------
`default_nettype none

module ida_conv (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic                        negative,
  input  wire logic [ida_pkg::VALUE_WIDTH-1:0] mag,
  input  wire logic                        take,
  output logic                             ready,
  output ida_pkg::conv_res_t               res,
  output logic [ida_pkg::BCD_W-1:0]        bcd
);
  import ida_pkg::*;

  conv_state_t            state, state_next;
  logic [VALUE_WIDTH-1:0] shreg;
  logic [CNT_W-1:0]       cnt;
  logic                   neg;
  logic [BCD_W-1:0]       adj;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[4*i +: 4] = dabble_adj(bcd[4*i +: 4]);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CV_IDLE:  if (start) state_next = CV_SHIFT;
      CV_SHIFT: if (cnt == '0) state_next = CV_HOLD;
      CV_HOLD:  if (take) state_next = CV_IDLE;
      default:  state_next = CV_IDLE;
    endcase
  end

  always_comb begin
    ready        = (state == CV_IDLE);
    res.valid    = (state == CV_HOLD);
    res.negative = neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == CV_IDLE && start) begin
      shreg <= mag;
      bcd   <= '0;
      neg   <= negative;
      cnt   <= CNT_W'(VALUE_WIDTH - 1);
    end else if (state == CV_SHIFT) begin
      bcd   <= {adj[BCD_W-2:0], shreg[VALUE_WIDTH-1]};
      shreg <= {shreg[VALUE_WIDTH-2:0], 1'b0};
      cnt   <= cnt - 1'b1;
    end
  end

  a_cnt_steps: assert property (@(posedge clk) disable iff (rst)
    (state == CV_SHIFT && cnt != '0) |=> (cnt == $past(cnt) - 1'b1))
    else $error("converter bit count skipped");

  a_bcd_legal: assert property (@(posedge clk) disable iff (rst)
    (state == CV_HOLD) |-> bcd_ok(bcd))
    else $error("converter produced a digit above nine");

endmodule

`default_nettype wire

// ===== design/ida_emit.sv =====
// -----------------------------------------------------------------------------
// ida_emit
// Character sequencer: drops leading zeros, adds the sign, sends one digit
// per transfer through a registered output stage.
// -----------------------------------------------------------------------------
`default_nettype none

module ida_emit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ida_pkg::conv_res_t        res,
  input  wire logic [ida_pkg::BCD_W-1:0] bcd,
  output logic                           take,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [ida_pkg::CHAR_W-1:0]     m_tdata,  // [7:0] char_out
  output logic                           m_tlast   // last
);
  import ida_pkg::*;

  emit_state_t       state, state_next;
  logic [BCD_W-1:0]  dig;
  logic [LEFT_W-1:0] left;
  logic              neg;

  logic              out_free;
  logic              top_zero;
  logic              shift;
  logic              issue;
  logic [CHAR_W-1:0] issue_char;
  logic              issue_last;

  assign out_free = !m_tvalid || m_tready;
  assign top_zero = (dig[BCD_W-1 -: 4] == 4'd0);

  always_comb begin
    state_next = state;
    case (state)
      EM_IDLE:  if (res.valid) state_next = EM_SKIP;
      EM_SKIP: begin
        if (!(top_zero && left > LEFT_W'(1))) state_next = neg ? EM_SIGN : EM_DIGIT;
      end
      EM_SIGN:  if (out_free) state_next = EM_DIGIT;
      EM_DIGIT: if (out_free && left == LEFT_W'(1)) state_next = EM_IDLE;
      default:  state_next = EM_IDLE;
    endcase
  end

  always_comb begin
    take       = 1'b0;
    shift      = 1'b0;
    issue      = 1'b0;
    issue_char = ASCII_ZERO;
    issue_last = 1'b0;
    case (state)
      EM_IDLE:  take = res.valid;
      EM_SKIP:  shift = top_zero && left > LEFT_W'(1);
      EM_SIGN: begin
        issue      = out_free;
        issue_char = ASCII_MINUS;
      end
      EM_DIGIT: begin
        issue      = out_free;
        shift      = out_free;
        issue_char = ASCII_ZERO + {4'd0, dig[BCD_W-1 -: 4]};
        issue_last = (left == LEFT_W'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= EM_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (issue) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dig  <= bcd;
      neg  <= res.negative;
      left <= LEFT_W'(NUM_DIGITS);
    end else if (shift) begin
      dig  <= {dig[BCD_W-5:0], 4'd0};
      left <= left - 1'b1;
    end
    if (issue) begin
      m_tdata <= issue_char;
      m_tlast <= issue_last;
    end
  end

  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == EM_SKIP || state == EM_SIGN || state == EM_DIGIT) |-> (left != '0))
    else $error("digit count ran out while emitting");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == ASCII_MINUS ||
                  (m_tdata >= ASCII_ZERO && m_tdata <= ASCII_ZERO + 8'd9)))
    else $error("output character is neither a digit nor a minus sign");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata == ASCII_MINUS) |-> !m_tlast)
    else $error("minus sign marked as last character");

endmodule

`default_nettype wire

// ===== design/int_to_decimal_ascii_core.sv =====
// -----------------------------------------------------------------------------
// int_to_decimal_ascii_core
// Formats a binary number as decimal ASCII text, most significant digit first.
// -----------------------------------------------------------------------------
// One transfer in (value in tdata, signed flag in tuser) gives one to twenty
// character transfers out, the final one with tlast. A negative signed value
// is led by '-'; zero prints as '0'. The magnitude is converted by a shift and
// add 3 unit, one bit per cycle: it loads the number, shifts all 64 bits and
// then holds the result until the emitter takes it. The emitter takes the
// result, drops leading zeros one at a time (up to 19), finds the first digit,
// then sends the sign, if any, and each digit when the sink is ready. The
// converter takes the next number as soon as its result has moved to the
// emitter, so conversion of one number overlaps emission of the previous. A
// stalled sink holds the emitter, and the converter waits with its result
// until the emitter is free.
`default_nettype none

module int_to_decimal_ascii_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [ida_pkg::IN_W-1:0]  s_tdata,  // [63:0] value
  input  wire logic                      s_tuser,  // opcode
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [ida_pkg::CHAR_W-1:0]     m_tdata,  // [7:0] char_out
  output logic                           m_tlast   // last
);
  import ida_pkg::*;

  logic [VALUE_WIDTH-1:0] v;
  logic                   negative;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   start;
  logic                   take;
  conv_res_t              res;
  logic [BCD_W-1:0]       bcd;

  assign v        = s_tdata[VALUE_WIDTH-1:0];
  assign negative = (s_tuser == OP_SIGNED) && v[VALUE_WIDTH-1];
  // most negative value wraps to 2^(W-1), read as unsigned
  assign mag      = negative ? (~v + 1'b1) : v;
  assign start    = s_tvalid && s_tready;

  ida_conv u_conv (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .negative (negative),
    .mag      (mag),
    .take     (take),
    .ready    (s_tready),
    .res      (res),
    .bcd      (bcd)
  );

  ida_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .bcd      (bcd),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// -----------------------------------------------------------------------------
// tb_top
// Testbench for int_to_decimal_ascii_core, the 64-bit decimal ASCII formatter.
// -----------------------------------------------------------------------------
// Numbers go in on the slave stream and their decimal text comes out on the
// master stream, one character per transfer. Each accepted number is formatted
// by a local model into a queue of expected characters. Each character that
// comes out is checked against the head of that queue. A directed set covers
// zero, the width limits, the most negative signed value and digit-count
// boundaries. Random numbers then run in three phases: two with stream
// back-pressure in both mixes and one at full rate.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ida_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 120;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // Holds the expected text of accepted numbers not yet checked, oldest character first
  class text_ledger;
    text_char_t  pending_text[$];
    int unsigned errors;
    int unsigned chars_checked;

    function new();
      errors        = 0;
      chars_checked = 0;
    endfunction

    // Decimal text of one accepted number, appended to the pending text
    function void note_number(logic opcode, logic [IN_W-1:0] raw);
      logic [63:0] mask;
      logic [63:0] mag;
      logic        neg;
      logic [3:0]  digits[$];
      text_char_t  c;
      mask = (VALUE_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_WIDTH) - 64'd1);
      mag  = raw & mask;
      neg  = 1'b0;
      if (opcode == OP_SIGNED && mag[VALUE_WIDTH-1]) begin
        neg = 1'b1;
        mag = (~mag + 64'd1) & mask;
      end
      if (mag == 64'd0) begin
        c.ch   = ASCII_ZERO;
        c.last = 1'b1;
        pending_text.push_back(c);
        return;
      end
      while (mag != 64'd0) begin
        digits.push_front(4'(mag % 64'd10));
        mag = mag / 64'd10;
      end
      if (neg) begin
        c.ch   = ASCII_MINUS;
        c.last = 1'b0;
        pending_text.push_back(c);
      end
      foreach (digits[i]) begin
        c.ch   = ASCII_ZERO + CHAR_W'(digits[i]);
        c.last = (i == digits.size() - 1);
        pending_text.push_back(c);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic last);
      text_char_t want;
      chars_checked++;
      if (pending_text.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char %h last %b",
                 $time, ch, last);
        errors++;
        return;
      end
      want = pending_text.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: char mismatch: expected %h, actual %h", $time, want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: tlast mismatch: expected %b, actual %b", $time, want.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_text.size();
    endfunction
  endclass

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata  = '0;
  logic              s_tuser  = OP_UNSIGNED;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [CHAR_W-1:0] m_tdata;
  logic              m_tlast;

  text_ledger  ledger = new();
  int unsigned tx_idle_pct = 36;
  int unsigned rx_idle_pct = 64;
  int unsigned numbers_sent = 0;
  int unsigned signed_sent  = 0;
  int unsigned quiet_cycles = 0;

  int_to_decimal_ascii_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [63:0] value
    .s_tuser  (s_tuser),   // opcode
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [7:0] char_out
    .m_tlast  (m_tlast)    // last
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Output check and watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid === 1'b1 && m_tready) begin
        ledger.check_char(m_tdata, m_tlast);
      end
      if ((m_tvalid === 1'b1 && m_tready) || (s_tvalid && s_tready === 1'b1)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no transfer for %0d cycles, %0d characters pending",
                 $time, WATCHDOG_LIMIT, ledger.outstanding());
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_number(logic opcode, logic [IN_W-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= opcode;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    ledger.note_number(opcode, value);
    numbers_sent++;
    if (opcode == OP_SIGNED) signed_sent++;
  endtask

  // Sender holds off until all pending text has come out
  task automatic drain_text();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] pow10(int unsigned k);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < k; i++) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    case ($urandom_range(6))
      0:       v = {$urandom, $urandom};
      1:       v = 64'($urandom_range(1000));
      2:       v = pow10($urandom_range(19)) + 64'($urandom_range(2)) - 64'd1;
      3:       v = {$urandom, $urandom} >> $urandom_range(63);
      4:       v = {1'b1, 63'd0} + 64'($urandom_range(3)) - 64'd2;
      5:       v = 64'd0 - 64'($urandom_range(1000));
      default: v = {$urandom, $urandom} | {1'b1, 63'd0};
    endcase
    return v;
  endfunction

  task automatic random_phase(int unsigned tx_pct, int unsigned rx_pct, int unsigned count);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int unsigned n = 0; n < count; n++) begin
      send_number(logic'($urandom_range(1)), random_value());
      if ($urandom_range(39) == 0) drain_text();
    end
    drain_text();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero, width limits, most negative signed, digit-count edges
    send_number(OP_UNSIGNED, 64'd0);
    send_number(OP_SIGNED,   64'd0);
    send_number(OP_UNSIGNED, 64'd1);
    send_number(OP_SIGNED,   64'd1);
    send_number(OP_UNSIGNED, {64{1'b1}});
    send_number(OP_SIGNED,   {64{1'b1}});
    send_number(OP_SIGNED,   {1'b1, 63'd0});
    send_number(OP_UNSIGNED, {1'b1, 63'd0});
    send_number(OP_SIGNED,   {1'b0, {63{1'b1}}});
    send_number(OP_SIGNED,   {1'b1, 62'd0, 1'b1});
    send_number(OP_UNSIGNED, 64'd9);
    send_number(OP_UNSIGNED, 64'd10);
    send_number(OP_SIGNED,   64'd99);
    send_number(OP_UNSIGNED, 64'd100);
    send_number(OP_SIGNED,   64'd0 - 64'd10);
    send_number(OP_SIGNED,   64'd0 - 64'd9);
    send_number(OP_UNSIGNED, pow10(19) - 64'd1);
    send_number(OP_UNSIGNED, pow10(19));
    send_number(OP_SIGNED,   pow10(19));
    send_number(OP_SIGNED,   pow10(18));
    send_number(OP_UNSIGNED, 64'h5555_5555_5555_5555);
    send_number(OP_SIGNED,   64'hAAAA_AAAA_AAAA_AAAA);
    drain_text();

    random_phase(36, 64, 84);
    random_phase(64, 36, 84);
    random_phase(0, 0, 84);

    // Room for any stray characters after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);

    if (ledger.outstanding() != 0) begin
      $display("%0t: %0d expected characters never arrived", $time, ledger.outstanding());
    end
    $display("Formatted %0d numbers (%0d read as signed), %0d characters checked,",
             numbers_sent, signed_sent, ledger.chars_checked);
    $display("under sender and receiver back-pressure in both mixes and at full rate.");
    if (ledger.errors == 0 && ledger.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ida_pkg.sv
design/ida_conv.sv
design/ida_emit.sv
design/int_to_decimal_ascii_core.sv
verif/tb_top.sv
